// File: rtl/core/bqlpf_pkg.sv
// Shared types, widths and helpers for the biquad low-pass filter.
// Depends on nothing; imported by the filter core and its checker.
package bqlpf_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_W       = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = 20;
    localparam int DELAY_W        = 40;

    // Shared multiplier: coefficient side is one bit wider than a coefficient
    // or than 2^F, so that (2^F - b0) and (b2 - a2) fit without overflow
    localparam int MUL_A_W = ((COEF_W > COEF_FRAC_BITS + 1) ? COEF_W : COEF_FRAC_BITS + 2) + 1;
    localparam int PROD_W  = MUL_A_W + SAMPLE_W;
    localparam int ACC_W   = ((PROD_W > DELAY_W) ? PROD_W : DELAY_W) + 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    // Request actions
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_PRESET = 1'b1;

    // Sequencer states: F* filter steps, P* preset steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6,
        ST_P0, ST_P1, ST_P2
    } t_state;

    // Saturate an accumulator value to the delay width
    function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DELAY_W:0] top;
        top = v[ACC_W-1:DELAY_W-1];
        if ((&top) || !(|top)) begin
            return v[DELAY_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DELAY_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DELAY_W-1){1'b1}}};
        end
    endfunction

    // Drop the fraction (rounding offset already added), then saturate to a sample
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]  sh;
        logic [ACC_W-SAMPLE_W:0]  top;
        sh  = v >>> COEF_FRAC_BITS;
        top = sh[ACC_W-1:SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            return sh[SAMPLE_W-1:0];
        end else if (sh[ACC_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: rtl/core/biquad_lowpass_filter.sv
// A filter request runs the steps F0 to F6 and a preset the steps P0 to P2; a new request
// is accepted only in idle, once the last one is through. The five products of a filter step
// all pass through one registered 21x16 multiplier, one per cycle.
// The last step waits while a previous output is still held on the output stage.
// Reset (synchronous, active low) clears the delay state, sets b0 to 1.0 and others to 0.
// Biquad section core; uses bqlpf_pkg.
module biquad_lowpass_filter
    import bqlpf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]    i_s_axis_tdata,   // [15:0] sample_in
    input  logic                   i_s_axis_tuser,   // [0] action
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [SAMPLE_W-1:0]    o_m_axis_tdata,   // [15:0] sample_out
    // Coefficient write port
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COEF_W-1:0]      i_cfg_data
);

    localparam logic signed [MUL_A_W-1:0] MUL_ONE =
        {{(MUL_A_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [COEF_W-1:0] B0_RESET =
        {{(COEF_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

    t_state r_state, n_state;

    logic signed [COEF_W-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [DELAY_W-1:0]  r_d1, r_d2;
    logic signed [SAMPLE_W-1:0] r_x, r_y;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_out_data;

    logic                       w_accept;
    logic                       w_out_free;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [SAMPLE_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]    w_prod_ext, w_d1_ext, w_d2_ext;

    // Sign-extend a coefficient to the multiplier width
    function automatic logic signed [MUL_A_W-1:0] ext_coef(input logic signed [COEF_W-1:0] c);
        return {{(MUL_A_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_d1_ext   = {{(ACC_W-DELAY_W){r_d1[DELAY_W-1]}}, r_d1};
    assign w_d2_ext   = {{(ACC_W-DELAY_W){r_d2[DELAY_W-1]}}, r_d2};
    assign w_prod     = w_mul_a * w_mul_b;

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_axis_tuser == ACT_PRESET) ? ST_P0 : ST_F0;
                end
            end
            ST_F0: n_state = ST_F1;
            ST_F1: n_state = ST_F2;
            ST_F2: n_state = ST_F3;
            ST_F3: n_state = ST_F4;
            ST_F4: n_state = ST_F5;
            ST_F5: n_state = ST_F6;
            ST_F6: n_state = w_out_free ? ST_IDLE : ST_F6;
            ST_P0: n_state = ST_P1;
            ST_P1: n_state = ST_P2;
            ST_P2: n_state = w_out_free ? ST_IDLE : ST_P2;
            default: n_state = ST_IDLE;
        endcase
    end

    // Multiplier operand selection per step; the last step repeats the
    // previous product so a stalled output keeps it in the product register
    always_comb begin
        w_mul_a = ext_coef(r_b0);
        w_mul_b = r_x;
        unique case (r_state)
            ST_F0: begin
                w_mul_a = ext_coef(r_b0);
                w_mul_b = r_x;
            end
            ST_F2: begin
                w_mul_a = ext_coef(r_b1);
                w_mul_b = r_x;
            end
            ST_F3: begin
                w_mul_a = ext_coef(r_a1);
                w_mul_b = r_y;
            end
            ST_F4: begin
                w_mul_a = ext_coef(r_b2);
                w_mul_b = r_x;
            end
            ST_F5: begin
                w_mul_a = ext_coef(r_a2);
                w_mul_b = r_y;
            end
            ST_F6: begin
                w_mul_a = ext_coef(r_a2);
                w_mul_b = r_y;
            end
            ST_P0: begin
                w_mul_a = MUL_ONE - ext_coef(r_b0);
                w_mul_b = r_x;
            end
            ST_P1: begin
                w_mul_a = ext_coef(r_b2) - ext_coef(r_a2);
                w_mul_b = r_x;
            end
            ST_P2: begin
                w_mul_a = ext_coef(r_b2) - ext_coef(r_a2);
                w_mul_b = r_x;
            end
            default: begin
                w_mul_a = ext_coef(r_b0);
                w_mul_b = r_x;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= B0_RESET;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_B0:  r_b0 <= i_cfg_data;
                REG_B1:  r_b1 <= i_cfg_data;
                REG_B2:  r_b2 <= i_cfg_data;
                REG_A1:  r_a1 <= i_cfg_data;
                REG_A2:  r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Delay state: write d1 in the next-to-last step and d2 in the last step of each sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            case (r_state)
                ST_F5: r_d1 <= sat_delay(r_acc);
                ST_F6: begin
                    if (w_out_free) begin
                        r_d2 <= sat_delay(r_acc - w_prod_ext);
                    end
                end
                ST_P1: r_d1 <= sat_delay(w_prod_ext);
                ST_P2: begin
                    if (w_out_free) begin
                        r_d2 <= sat_delay(w_prod_ext);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath: capture sample, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_accept) begin
            r_x <= i_s_axis_tdata;
        end
        case (r_state)
            ST_F1: r_acc <= w_prod_ext + w_d1_ext + ACC_HALF;
            ST_F2: r_y   <= sat_sample(r_acc);
            ST_F3: r_acc <= w_prod_ext + w_d2_ext;
            ST_F4: r_acc <= r_acc - w_prod_ext;
            ST_F5: r_acc <= w_prod_ext;
            default: ;
        endcase
    end

    // Output stage: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_F6 || r_state == ST_P2) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_state == ST_F6) begin
                r_out_data <= r_y;
            end else if (r_state == ST_P2) begin
                r_out_data <= r_x;
            end
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

endmodule

// File: rtl/core/bqlpf_chk.sv
// Port-level checker for the biquad low-pass filter, bound to the filter core module.
// Uses bqlpf_pkg for port widths.
module bqlpf_chk
    import bqlpf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [SAMPLE_W-1:0] o_m_axis_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Drop ready while a request is in work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready high right after a request was accepted");

    // Finishing a request always leaves a result on the output
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_s_axis_tready) |-> o_m_axis_tvalid)
        else $error("request finished without a result");

    // Reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind biquad_lowpass_filter bqlpf_chk u_bqlpf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
